>>> sv/plasma_pixel_generator_core_macros.svh
// Assertion macros for the plasma pixel generator
`ifndef PLASMA_PIXEL_GENERATOR_CORE_MACROS_SVH
`define PLASMA_PIXEL_GENERATOR_CORE_MACROS_SVH

// Check a property on every rising edge of clk, out of reset
`define PPG_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition
`define PPG_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> sv/ppg_pkg.sv
`timescale 1ns / 1ps

package ppg_pkg;

    localparam int RASTER_WIDTH  = 128;
    localparam int RASTER_HEIGHT = 64;
    localparam int COL_CNT_W     = (RASTER_WIDTH > 1) ? $clog2(RASTER_WIDTH) : 1;
    localparam int ROW_CNT_W     = (RASTER_HEIGHT > 1) ? $clog2(RASTER_HEIGHT) : 1;

    localparam int PHASE_W   = 8;
    localparam int SHADE_W   = 8;
    localparam int COLUMN_W  = 7;
    localparam int ROW_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int TURN3_4      = 270;
    localparam int WAVE_AMP     = 90;
    localparam int SINE_SHIFT   = 14;
    localparam int SHADE_PEAK   = 121;
    localparam int SHADE_PERIOD = 242;
    localparam int WAVE_COUNT   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ   = 3'd0,
        REG_SPEED1 = 3'd1,
        REG_SPEED2 = 3'd2,
        REG_SPEED3 = 3'd3,
        REG_SPEED4 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
    } ppg_issue_t;

    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] value;
    } ppg_wave_t;

    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0, 15'd285, 15'd571, 15'd857, 15'd1142, 15'd1427, 15'd1712, 15'd1996,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3685, 15'd3963,
        15'd4240, 15'd4516, 15'd4790, 15'd5062, 15'd5334, 15'd5603, 15'd5871,
        15'd6137, 15'd6401, 15'd6663, 15'd6924, 15'd7182, 15'd7438, 15'd7691,
        15'd7943, 15'd8191, 15'd8438, 15'd8682, 15'd8923, 15'd9161, 15'd9397,
        15'd9630, 15'd9860, 15'd10086, 15'd10310, 15'd10531, 15'd10748, 15'd10963,
        15'd11173, 15'd11381, 15'd11585, 15'd11785, 15'd11982, 15'd12175,
        15'd12365, 15'd12550, 15'd12732, 15'd12910, 15'd13084, 15'd13254,
        15'd13420, 15'd13582, 15'd13740, 15'd13894, 15'd14043, 15'd14188,
        15'd14329, 15'd14466, 15'd14598, 15'd14725, 15'd14848, 15'd14967,
        15'd15081, 15'd15190, 15'd15295, 15'd15395, 15'd15491, 15'd15582,
        15'd15668, 15'd15749, 15'd15825, 15'd15897, 15'd15964, 15'd16025,
        15'd16082, 15'd16135, 15'd16182, 15'd16224, 15'd16261, 15'd16294,
        15'd16321, 15'd16344, 15'd16361, 15'd16374, 15'd16381, 15'd16384
    };

    function automatic logic [SHADE_W-1:0] shade_of(input logic [PHASE_W-1:0] i);
        logic [SHADE_W-1:0] s;
        if (i <= PHASE_W'(SHADE_PEAK))
            s = {i[SHADE_W-2:0], 1'b0};
        else if (i <= PHASE_W'(SHADE_PERIOD))
            s = SHADE_W'({PHASE_W'(PHASE_W'(SHADE_PERIOD) - i), 1'b0});
        else
            s = SHADE_W'({PHASE_W'(i - PHASE_W'(SHADE_PERIOD)), 1'b0});
        return s;
    endfunction

endpackage

>>> sv/ppg_wave_unit.sv
`timescale 1ns / 1ps

module ppg_wave_unit
    import ppg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         frequency,
    input  ppg_issue_t         issue,
    output ppg_wave_t          wave
);

    logic [7:0]         freq_sat;
    logic [15:0]        prod;
    logic [7:0]         frac_reg;
    logic               frac_valid_reg;
    logic [16:0]        scaled;
    logic [8:0]         deg;
    logic [6:0]         fold;
    logic               neg;
    logic [21:0]        amp_full;
    logic [6:0]         amp;
    logic [PHASE_W-1:0] wave_value_next;
    logic [PHASE_W-1:0] wave_value_reg;
    logic               wave_valid_reg;

    assign freq_sat = (frequency == 8'd0) ? 8'd1 : frequency;
    assign prod     = 16'(issue.phase) * 16'(freq_sat);

    // degree depends only on the low byte of index * frequency
    assign scaled = 17'(frac_reg) * 17'(FULL_TURN);
    assign deg    = scaled[16:8];

    always_comb
    begin
        neg  = 1'b0;
        fold = 7'd0;
        if (deg <= 9'(QUARTER_TURN))
            fold = 7'(deg);
        else if (deg <= 9'(HALF_TURN))
            fold = 7'(9'(HALF_TURN) - deg);
        else if (deg <= 9'(TURN3_4))
        begin
            fold = 7'(deg - 9'(HALF_TURN));
            neg  = 1'b1;
        end
        else
        begin
            fold = 7'(9'(FULL_TURN) - deg);
            neg  = 1'b1;
        end
    end

    assign amp_full        = 22'(QUARTER_SINE[fold]) * 22'(WAVE_AMP);
    assign amp             = 7'(amp_full >> SINE_SHIFT);
    assign wave_value_next = neg ? PHASE_W'(8'd0 - 8'(amp)) : PHASE_W'(amp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_valid_reg <= 1'b0;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            frac_valid_reg <= issue.valid;
            wave_valid_reg <= frac_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg       <= prod[7:0];
        wave_value_reg <= wave_value_next;
    end

    assign wave.valid = wave_valid_reg;
    assign wave.value = wave_value_reg;

endmodule

>>> sv/plasma_pixel_generator_core.sv
`timescale 1ns / 1ps
// Plasma raster pixel generator.
// Input channel: in_valid / in_stall with pixel_request. A word with
// pixel_request high asks for the next pixel; a word with it low is taken
// and gives no result. Output channel: out_valid / out_stall with shade,
// column, row, row_end and frame_end, raster scanned left to right, top down.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is the wave frequency (0 acts as 1), 1 to 4 the frame phase speeds.
// cfg_ready is always high; write only while no pixel is in flight.
// Pipeline: a pixel word is taken, then the four wave values go one per cycle
// through the shared multiply and sine lookup unit (two register stages), are
// summed and the result is loaded into the output register. in_stall is high
// from acceptance until the result is loaded; no new word is taken meanwhile.
// A word with pixel_request low is taken while idle and leaves in_stall low.
// When out_stall holds a result, the next pixel waits finished in the block
// until the output register frees. Reset clears all phases and the raster
// position and loads the register defaults.
module plasma_pixel_generator_core
    import ppg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 pixel_request,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SHADE_W-1:0]   shade,
    output logic [COLUMN_W-1:0]  column,
    output logic [ROW_W-1:0]     row,
    output logic                 row_end,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           freq_reg;
    logic [7:0]           speed1_reg, speed2_reg, speed3_reg, speed4_reg;
    logic [PHASE_W-1:0]   fa_reg, fb_reg, fc_reg, fd_reg;
    logic [PHASE_W-1:0]   fa_next, fb_next, fc_next, fd_next;
    logic [PHASE_W-1:0]   ra_reg, rb_reg, cc_reg, cd_reg;
    logic [PHASE_W-1:0]   ra_next, rb_next, cc_next, cd_next;
    logic [COL_CNT_W-1:0] col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [2:0]           issue_cnt_reg, issue_cnt_next;
    logic [1:0]           done_cnt_reg, done_cnt_next;
    logic [PHASE_W-1:0]   acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SHADE_W-1:0]   shade_reg;
    logic [COLUMN_W-1:0]  column_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 row_end_reg, frame_end_reg;
    logic                 load;
    logic                 last_col, last_row;
    ppg_issue_t           issue;
    ppg_wave_t            wave;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= 8'd1;
            speed1_reg <= 8'd4;
            speed2_reg <= 8'd2;
            speed3_reg <= 8'd4;
            speed4_reg <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FREQ:   freq_reg   <= cfg_data;
                REG_SPEED1: speed1_reg <= cfg_data;
                REG_SPEED2: speed2_reg <= cfg_data;
                REG_SPEED3: speed3_reg <= cfg_data;
                REG_SPEED4: speed4_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        issue.valid = (state_reg == S_CALC) && !issue_cnt_reg[2];
        case (issue_cnt_reg[1:0])
            2'd0:    issue.phase = ra_reg;
            2'd1:    issue.phase = rb_reg;
            2'd2:    issue.phase = cc_reg;
            default: issue.phase = cd_reg;
        endcase
    end

    ppg_wave_unit u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .frequency (freq_reg),
        .issue     (issue),
        .wave      (wave)
    );

    assign load     = (state_reg == S_HOLD) && (!out_valid_reg || !out_stall);
    assign last_col = (col_reg == COL_CNT_W'(RASTER_WIDTH - 1));
    assign last_row = (row_cnt_reg == ROW_CNT_W'(RASTER_HEIGHT - 1));

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        done_cnt_next  = done_cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        fa_next = fa_reg; fb_next = fb_reg; fc_next = fc_reg; fd_next = fd_reg;
        ra_next = ra_reg; rb_next = rb_reg; cc_next = cc_reg; cd_next = cd_reg;
        col_next     = col_reg;
        row_cnt_next = row_cnt_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                issue_cnt_next = 3'd0;
                done_cnt_next  = 2'd0;
                acc_next       = '0;
                if (in_valid && pixel_request)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                if (issue.valid)
                    issue_cnt_next = issue_cnt_reg + 3'd1;
                if (wave.valid)
                begin
                    acc_next      = acc_reg + wave.value;
                    done_cnt_next = done_cnt_reg + 2'd1;
                    if (done_cnt_reg == 2'(WAVE_COUNT - 1))
                        state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!last_col)
                    begin
                        col_next = col_reg + COL_CNT_W'(1);
                        cc_next  = cc_reg + 8'd1;
                        cd_next  = cd_reg + 8'd2;
                    end
                    else
                    begin
                        col_next = '0;
                        if (!last_row)
                        begin
                            row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
                            ra_next = ra_reg + 8'd2;
                            rb_next = rb_reg + 8'd1;
                            cc_next = fc_reg;
                            cd_next = fd_reg;
                        end
                        else
                        begin
                            row_cnt_next = '0;
                            fa_next = fa_reg + speed1_reg;
                            fb_next = fb_reg - speed2_reg;
                            fc_next = fc_reg + speed3_reg;
                            fd_next = fd_reg - speed4_reg;
                            ra_next = fa_next;
                            rb_next = fb_next;
                            cc_next = fc_next;
                            cd_next = fd_next;
                        end
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= 3'd0;
            done_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
            fa_reg <= '0; fb_reg <= '0; fc_reg <= '0; fd_reg <= '0;
            ra_reg <= '0; rb_reg <= '0; cc_reg <= '0; cd_reg <= '0;
            col_reg     <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            done_cnt_reg  <= done_cnt_next;
            out_valid_reg <= out_valid_next;
            fa_reg <= fa_next; fb_reg <= fb_next; fc_reg <= fc_next; fd_reg <= fd_next;
            ra_reg <= ra_next; rb_reg <= rb_next; cc_reg <= cc_next; cd_reg <= cd_next;
            col_reg     <= col_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load)
        begin
            shade_reg     <= shade_of(acc_reg);
            column_reg    <= COLUMN_W'(col_reg);
            row_reg       <= ROW_W'(row_cnt_reg);
            row_end_reg   <= last_col;
            frame_end_reg <= last_col && last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign shade     = shade_reg;
    assign column    = column_reg;
    assign row       = row_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> sv/ppg_checker.sv
`timescale 1ns / 1ps
`include "plasma_pixel_generator_core_macros.svh"

module ppg_checker
    import ppg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 pixel_request,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [SHADE_W-1:0]   shade,
    input logic [COLUMN_W-1:0]  column,
    input logic [ROW_W-1:0]     row,
    input logic                 row_end,
    input logic                 frame_end,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [7:0]           cfg_data
);

    `PPG_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "word dropped under stall")
    `PPG_ASSERT_HOLD(a_shade_hold, out_valid && out_stall, shade, "stalled shade changed")
    `PPG_ASSERT_CLK(a_frame_row, out_valid && frame_end |-> row_end, "frame end off row end")
    `PPG_ASSERT_CLK(a_shade_range, out_valid |-> shade <= SHADE_W'(SHADE_PERIOD), "shade out of range")
    `PPG_ASSERT_CLK(a_pixel_busy, in_valid && !in_stall && pixel_request |=> in_stall, "busy not raised")

endmodule

bind plasma_pixel_generator_core ppg_checker u_ppg_checker (.*);

>>> tb/sv/plasma_pixel_generator_core_test.sv
`timescale 1ns / 1ps

module plasma_pixel_generator_core_test;
    import ppg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_PIXELS  = 2000;
    localparam int PHASE_PIXELS   = 200;
    localparam int MAX_PRINTS     = 200;
    localparam int IDLE_PCT [0:2] = '{0, 12, 40};

    typedef struct packed {
        logic [SHADE_W-1:0]  shade;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                row_end;
        logic                frame_end;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 pixel_request = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SHADE_W-1:0]   shade;
    logic [COLUMN_W-1:0]  column;
    logic [ROW_W-1:0]     row;
    logic                 row_end;
    logic                 frame_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    logic [7:0]         freq_reg = 8'd1;
    logic [PHASE_W-1:0] speed_a = 8'd4;
    logic [PHASE_W-1:0] speed_b = 8'd2;
    logic [PHASE_W-1:0] speed_c = 8'd4;
    logic [PHASE_W-1:0] speed_d = 8'd2;
    logic [PHASE_W-1:0] frame_a = '0;
    logic [PHASE_W-1:0] frame_b = '0;
    logic [PHASE_W-1:0] frame_c = '0;
    logic [PHASE_W-1:0] frame_d = '0;
    logic [PHASE_W-1:0] row_a = '0;
    logic [PHASE_W-1:0] row_b = '0;
    logic [PHASE_W-1:0] col_c = '0;
    logic [PHASE_W-1:0] col_d = '0;
    int                 col_pos = 0;
    int                 row_pos = 0;

    pixel_t expected_pixels [$];

    int mismatches = 0;
    int pixels_seen = 0;
    int row_ends_seen = 0;
    int frame_ends_seen = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;
    int stall_pct = 0;
    int hold_requests = 0;

    plasma_pixel_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_request (pixel_request),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shade         (shade),
        .column        (column),
        .row           (row),
        .row_end       (row_end),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [PHASE_W-1:0] wave_value(input logic [PHASE_W-1:0] idx);
        int f;
        int deg;
        int mag;
        logic neg;
        f = (freq_reg == 8'd0) ? 1 : int'(freq_reg);
        deg = (int'(idx) * FULL_TURN * f / (2 ** PHASE_W)) % FULL_TURN;
        neg = deg > HALF_TURN;
        if (deg <= QUARTER_TURN)
            mag = QUARTER_SINE[deg];
        else if (deg <= HALF_TURN)
            mag = QUARTER_SINE[HALF_TURN - deg];
        else if (deg <= TURN3_4)
            mag = QUARTER_SINE[deg - HALF_TURN];
        else
            mag = QUARTER_SINE[FULL_TURN - deg];
        mag = (WAVE_AMP * mag) >> SINE_SHIFT;
        return neg ? PHASE_W'(-mag) : PHASE_W'(mag);
    endfunction

    function automatic logic [SHADE_W-1:0] shade_map(input logic [PHASE_W-1:0] z);
        int i;
        i = int'(z);
        if (i <= SHADE_PEAK)
            return SHADE_W'(2 * i);
        if (i <= SHADE_PERIOD)
            return SHADE_W'(2 * (SHADE_PERIOD - i));
        return SHADE_W'(2 * (i - SHADE_PERIOD));
    endfunction

    // advance the raster by one pixel
    function automatic pixel_t next_pixel();
        pixel_t p;
        logic [PHASE_W-1:0] z;
        z = wave_value(row_a) + wave_value(row_b) + wave_value(col_c) + wave_value(col_d);
        p.shade = shade_map(z);
        p.column = COLUMN_W'(col_pos);
        p.row = ROW_W'(row_pos);
        p.row_end = 1'b0;
        p.frame_end = 1'b0;
        col_c = col_c + 8'd1;
        col_d = col_d + 8'd2;
        col_pos++;
        if (col_pos >= RASTER_WIDTH)
        begin
            p.row_end = 1'b1;
            col_pos = 0;
            row_a = row_a + 8'd2;
            row_b = row_b + 8'd1;
            row_pos++;
            if (row_pos >= RASTER_HEIGHT)
            begin
                p.frame_end = 1'b1;
                row_pos = 0;
                frame_a = frame_a + speed_a;
                frame_b = frame_b - speed_b;
                frame_c = frame_c + speed_c;
                frame_d = frame_d - speed_d;
                row_a = frame_a;
                row_b = frame_b;
            end
            col_c = frame_c;
            col_d = frame_d;
        end
        return p;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(12, 48);
    endfunction

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_word(input logic request);
        in_valid <= 1'b1;
        pixel_request <= request;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (request)
            expected_pixels.push_back(next_pixel());
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic wait_for_pixels();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FREQ:   freq_reg = value;
            REG_SPEED1: speed_a = value;
            REG_SPEED2: speed_b = value;
            REG_SPEED3: speed_c = value;
            REG_SPEED4: speed_d = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_registers(input logic [7:0] freq, input logic [7:0] s1,
                                     input logic [7:0] s2, input logic [7:0] s3,
                                     input logic [7:0] s4);
        write_reg(REG_FREQ, freq);
        write_reg(REG_SPEED1, s1);
        write_reg(REG_SPEED2, s2);
        write_reg(REG_SPEED3, s3);
        write_reg(REG_SPEED4, s4);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        repeat (4)
            send_word(1'b1);
        wait_for_pixels();
    endtask

    task automatic test_idle_words();
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        pause_sender(3);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        wait_for_pixels();
    endtask

    task automatic test_frequency_extremes();
        program_registers(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        repeat (3)
            send_word(1'b1);
        wait_for_pixels();
        program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        repeat (3)
            send_word(1'b1);
        wait_for_pixels();
    endtask

    task automatic test_unknown_index();
        for (int i = int'(REG_SPEED4) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        repeat (3)
            send_word(1'b1);
        wait_for_pixels();
    endtask

    task automatic test_back_pressure();
        stall_pct = 0;
        hold_requests++;
        repeat (12)
            send_word(1'b1);
        wait_for_pixels();
    endtask

    task automatic test_random_traffic();
        int gap_pct;
        int sent;
        for (int phase = 0; phase < RANDOM_PIXELS / PHASE_PIXELS; phase++)
        begin
            program_registers(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                              pick_reg_value(), pick_reg_value());
            gap_pct = IDLE_PCT[$urandom_range(0, 2)];
            stall_pct = IDLE_PCT[$urandom_range(0, 2)];
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                if ($urandom_range(0, 99) < gap_pct)
                    pause_sender(pick_gap());
                if ($urandom_range(0, 15) == 0)
                    send_word(1'b0);
                else
                begin
                    send_word(1'b1);
                    sent++;
                end
            end
            wait_for_pixels();
        end
    endtask

    initial
    begin : receiver_side
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report($sformatf("pixel with no request pending, column %0d row %0d",
                                 column, row));
            else
            begin
                pixel_t want;
                want = expected_pixels.pop_front();
                check_field("shade", shade, want.shade);
                check_field("column", 8'(column), 8'(want.column));
                check_field("row", 8'(row), 8'(want.row));
                check_field("row_end", 8'(row_end), 8'(want.row_end));
                check_field("frame_end", 8'(frame_end), 8'(want.frame_end));
            end
            pixels_seen++;
            if (row_end)
                row_ends_seen++;
            if (frame_end)
                frame_ends_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d cycles with no word moving", WATCHDOG_LIMIT);
            $display("plasma_pixel_generator_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_idle_words();
        test_frequency_extremes();
        test_unknown_index();
        test_back_pressure();
        test_random_traffic();

        $display("checked %0d pixels, %0d row ends, %0d frame ends, %0d register writes",
                 pixels_seen, row_ends_seen, frame_ends_seen, reg_writes);
        $display("covered reset values, idle words, extreme frequencies, unknown indexes, "
                 , "row wrap, long output hold-off and random stalls on both sides");
        if (mismatches == 0)
            $display("plasma_pixel_generator_core test passed");
        else
            $display("plasma_pixel_generator_core test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ppg_pkg.sv
sv/ppg_wave_unit.sv
sv/plasma_pixel_generator_core.sv
sv/ppg_checker.sv
tb/sv/plasma_pixel_generator_core_test.sv
